// File: hdl/mlcd_pkg.sv
// ----------------------------------------------------------------------------
// mlcd_pkg: shared types and constants of the memory LCD frame serializer.
// Configuration register indexes, result item types and the bit reversal.
// ----------------------------------------------------------------------------
package mlcd_pkg;

  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntW       = 3;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] RegBytesPerLine  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLinesPerFrame = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWriteCommand  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegVcomFlag      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegClearCommand  = 3'd4;

  localparam logic [7:0] ResetBytesPerLine  = 8'd50;
  localparam logic [7:0] ResetLinesPerFrame = 8'd240;
  localparam logic [7:0] ResetWriteCommand  = 8'd128;
  localparam logic [7:0] ResetVcomFlag      = 8'd64;
  localparam logic [7:0] ResetClearCommand  = 8'd32;

  localparam logic [7:0] MaxBytesPerLine = 8'd128;
  localparam logic [7:0] ZeroByte        = 8'h00;

  localparam logic KindData  = 1'b0;
  localparam logic KindClear = 1'b1;

  typedef struct packed {
    logic [7:0] bytes_per_line;
    logic [7:0] lines_per_frame;
    logic [7:0] write_command;
    logic [7:0] vcom_flag;
    logic [7:0] clear_command;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [CntW-1:0]       count;
  } res_set_t;

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

// File: hdl/mlcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// mlcd_cfg_regs: configuration register file.
// Holds the five line, frame and command registers written over the cfg port.
// ----------------------------------------------------------------------------
module mlcd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mlcd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  output mlcd_pkg::cfg_t                 cfg_o
);

  mlcd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mlcd_pkg::RegBytesPerLine:  cfg_d.bytes_per_line  = cfg_data_i;
        mlcd_pkg::RegLinesPerFrame: cfg_d.lines_per_frame = cfg_data_i;
        mlcd_pkg::RegWriteCommand:  cfg_d.write_command   = cfg_data_i;
        mlcd_pkg::RegVcomFlag:      cfg_d.vcom_flag       = cfg_data_i;
        mlcd_pkg::RegClearCommand:  cfg_d.clear_command   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_line  <= mlcd_pkg::ResetBytesPerLine;
      cfg_q.lines_per_frame <= mlcd_pkg::ResetLinesPerFrame;
      cfg_q.write_command   <= mlcd_pkg::ResetWriteCommand;
      cfg_q.vcom_flag       <= mlcd_pkg::ResetVcomFlag;
      cfg_q.clear_command   <= mlcd_pkg::ResetClearCommand;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/mlcd_framer.sv
// ----------------------------------------------------------------------------
// mlcd_framer: frame position tracking and result set generation.
// Forms the command, address, data and trailer bytes that one item causes.
// ----------------------------------------------------------------------------
module mlcd_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlcd_pkg::cfg_t      cfg_i,
  input  logic                accept_i,
  input  logic                kind_i,
  input  logic [7:0]          pixel_byte_i,
  output mlcd_pkg::res_set_t  set_o
);

  logic       vcom_q, vcom_d;
  logic [7:0] line_q, line_d;
  logic [6:0] byte_q, byte_d;

  logic [7:0] bpl_eff, lpf_eff;
  logic       line_done, frame_done;
  logic [7:0] cmd_bits;
  logic [7:0] cmd_byte;
  logic [7:0] line_addr;
  logic       frame_first;

  always_comb begin
    bpl_eff = cfg_i.bytes_per_line;
    if (bpl_eff == 8'd0) begin
      bpl_eff = 8'd1;
    end else if (bpl_eff > mlcd_pkg::MaxBytesPerLine) begin
      bpl_eff = mlcd_pkg::MaxBytesPerLine;
    end
    lpf_eff = (cfg_i.lines_per_frame == 8'd0) ? 8'd1 : cfg_i.lines_per_frame;
  end

  assign line_done   = ({1'b0, byte_q} + 8'd1) >= bpl_eff;
  assign frame_done  = ({1'b0, line_q} + 9'd1) >= {1'b0, lpf_eff};
  assign frame_first = (line_q == 8'd0) && (byte_q == 7'd0);
  assign line_addr   = mlcd_pkg::bit_rev8(line_q + 8'd1);

  // The VCOM level toggles when an item that forms a command byte is accepted.
  assign cmd_bits = (kind_i == mlcd_pkg::KindClear) ? cfg_i.clear_command
                                                    : cfg_i.write_command;
  assign cmd_byte = cmd_bits | (~vcom_q ? cfg_i.vcom_flag : 8'd0);

  always_comb begin
    logic [mlcd_pkg::CntW-1:0] n;
    n = '0;
    for (int i = 0; i < mlcd_pkg::MaxResults; i++) begin
      set_o.res[i] = '0;
    end
    vcom_d = vcom_q;
    line_d = line_q;
    byte_d = byte_q;

    if (kind_i == mlcd_pkg::KindClear) begin
      set_o.res[0] = '{data: cmd_byte, start: 1'b1, last: 1'b0};
      set_o.res[1] = '{data: mlcd_pkg::ZeroByte, start: 1'b0, last: 1'b1};
      n = 3'd2;
      vcom_d = ~vcom_q;
      line_d = '0;
      byte_d = '0;
    end else begin
      if (frame_first) begin
        set_o.res[n] = '{data: cmd_byte, start: 1'b1, last: 1'b0};
        n = n + 3'd1;
        vcom_d = ~vcom_q;
      end
      if (byte_q == 7'd0) begin
        set_o.res[n] = '{data: line_addr, start: 1'b0, last: 1'b0};
        n = n + 3'd1;
      end
      set_o.res[n] = '{data: mlcd_pkg::bit_rev8(pixel_byte_i), start: 1'b0, last: 1'b0};
      n = n + 3'd1;
      if (line_done) begin
        set_o.res[n] = '{data: mlcd_pkg::ZeroByte, start: 1'b0, last: 1'b0};
        n = n + 3'd1;
        byte_d = '0;
        if (frame_done) begin
          set_o.res[n] = '{data: mlcd_pkg::ZeroByte, start: 1'b0, last: 1'b1};
          n = n + 3'd1;
          line_d = '0;
        end else begin
          line_d = line_q + 8'd1;
        end
      end else begin
        byte_d = byte_q + 7'd1;
      end
    end
    set_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcom_q <= 1'b1;
      line_q <= '0;
      byte_q <= '0;
    end else if (accept_i) begin
      vcom_q <= vcom_d;
      line_q <= line_d;
      byte_q <= byte_d;
    end
  end

endmodule

// File: hdl/mlcd_out_seq.sv
// ----------------------------------------------------------------------------
// mlcd_out_seq: result register and output sequencer.
// Holds the result set of one item and hands out one byte per cycle on tready.
// ----------------------------------------------------------------------------
module mlcd_out_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  mlcd_pkg::res_set_t  set_i,
  output logic                free_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o,
  output logic                m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  mlcd_pkg::res_t [mlcd_pkg::MaxResults-1:0] res_q;
  logic [mlcd_pkg::CntW-1:0] cnt_q;
  logic [mlcd_pkg::CntW-1:0] idx_q, idx_d;
  logic                      valid_q, valid_d;
  logic                      take, last_take;

  assign take      = valid_q && m_axis_tready_i;
  assign last_take = take && (idx_q == cnt_q - 3'd1);

  // A new item may load while the final byte of the previous one leaves.
  assign free_o = !valid_q || last_take;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (last_take) begin
      valid_d = 1'b0;
      idx_d   = '0;
    end else if (take) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= set_i.res;
      cnt_q <= set_i.count;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = res_q[idx_q].data;
  assign m_axis_tuser_o  = res_q[idx_q].start;
  assign m_axis_tlast_o  = res_q[idx_q].last;

endmodule

// File: hdl/memory_lcd_frame_serializer_core.sv
// ----------------------------------------------------------------------------
// memory_lcd_frame_serializer_core: memory LCD update byte stream generator.
// An item's first result byte is shown in the cycle after it is accepted;
// the result register sends one byte per cycle while the sink is ready;
// an item yields one to five bytes, one for a plain data byte in a line.
// Reset clears the frame position, sets VCOM high, loads register defaults.
// ----------------------------------------------------------------------------
module memory_lcd_frame_serializer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mlcd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  // Input items.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // [7:0] pixel_byte
  input  logic                         s_axis_tuser_i,  // [0] kind
  // Result items.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [7:0]                   m_axis_tdata_o,  // [7:0] serial_byte
  output logic                         m_axis_tuser_o,  // [0] transfer_start
  output logic                         m_axis_tlast_o   // transfer_end
);

  mlcd_pkg::cfg_t     cfg;
  mlcd_pkg::res_set_t set;
  logic               free;
  logic               accept;

  assign s_axis_tready_o = free;
  assign accept          = s_axis_tvalid_i && free;

  mlcd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mlcd_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (accept),
    .kind_i       (s_axis_tuser_i),
    .pixel_byte_i (s_axis_tdata_i),
    .set_o        (set)
  );

  mlcd_out_seq u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .set_i           (set),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
